// ===== sv/triangle_box_binner_macros.svh =====
// ----------------------------------------------------------------------------
// Triangle box binner assertion macros
// Shared property forms for the checkers of the binner, clocked on aclk and
// held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_BOX_BINNER_MACROS_SVH
`define TRIANGLE_BOX_BINNER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TBB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("binner check failed");

// Consequent must hold in the cycle after the antecedent.
`define TBB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("binner check failed");

`endif

// ===== sv/tbb_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle box binner package
// Widths, register indices, shared types and helper functions.
// ----------------------------------------------------------------------------
package tbb_pkg;

    localparam int POINT_CAPACITY = 1024;
    localparam int BOXES_PER_SIDE = 4;

    localparam int VTX_W   = 10;
    localparam int COORD_W = 24;
    localparam int FRAC_W  = 8;
    localparam int BOX_W   = 16;
    localparam int ID_W    = 32;
    localparam int GL_W    = 5;
    localparam int BL_W    = 4;
    localparam int AXES    = 3;

    localparam int PT_AW = (POINT_CAPACITY > 1) ? $clog2(POINT_CAPACITY) : 1;
    localparam int CNT_W = $clog2(BOXES_PER_SIDE + 1);
    localparam int SH_W  = 5;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 80;
    localparam int CFG_AW    = 4;
    localparam int CFG_DW    = 32;
    localparam int CFG_IW    = 2;

    localparam logic [CFG_IW-1:0] REG_GRID_LEVELS = 2'd0;
    localparam logic [CFG_IW-1:0] REG_BOX_LEVEL   = 2'd1;
    localparam logic [CFG_IW-1:0] REG_FIRST_ID    = 2'd2;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    // x in the lowest bits
    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } point_t;

    typedef struct packed {
        cnt_t [AXES-1:0] lo;
        cnt_t [AXES-1:0] hi;
    } box_range_t;

    typedef struct packed {
        logic load;
        logic acc;
    } bound_ctl_t;

    function automatic logic [PT_AW-1:0] pt_index(input logic [VTX_W-1:0] v);
        logic [VTX_W+PT_AW-1:0] w;
        begin
            w = {{PT_AW{1'b0}}, v};
            return w[PT_AW-1:0];
        end
    endfunction

    function automatic logic pt_in_range(input logic [VTX_W-1:0] v);
        logic [VTX_W+PT_AW-1:0] w;
        begin
            w = {{PT_AW{1'b0}}, v};
            return w < (VTX_W + PT_AW)'(POINT_CAPACITY);
        end
    endfunction

    // Boxes per side: 2^(grid - box), at least one, at most BOXES_PER_SIDE.
    function automatic cnt_t box_count(input logic [GL_W-1:0] gl,
                                       input logic [BL_W-1:0] bl);
        logic [31:0] full;
        cnt_t        res;
        begin
            if ({1'b0, bl} >= gl) begin
                full = 32'd1;
            end else begin
                full = 32'd1 << (gl - {1'b0, bl});
            end
            if (full > 32'(BOXES_PER_SIDE)) begin
                res = CNT_W'(BOXES_PER_SIDE);
            end else begin
                res = full[CNT_W-1:0];
            end
            return res;
        end
    endfunction

endpackage

// ===== sv/tbb_point_mem.sv =====
// ----------------------------------------------------------------------------
// Triangle box binner point memory
// One write port and one registered read port over the point table.
// ----------------------------------------------------------------------------
module tbb_point_mem import tbb_pkg::*; (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [VTX_W-1:0] wr_addr,
    input  point_t           wr_data,
    input  logic             rd_en,
    input  logic [VTX_W-1:0] rd_addr,
    output point_t           rd_data
);

    point_t mem [POINT_CAPACITY];
    point_t rd_q_reg;
    logic   in_range_reg;

    always_ff @(posedge aclk) begin
        if (wr_en && pt_in_range(wr_addr)) begin
            mem[pt_index(wr_addr)] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg     <= mem[pt_index(rd_addr)];
            in_range_reg <= pt_in_range(rd_addr);
        end
    end

    // Addresses beyond the table read as the origin.
    assign rd_data = in_range_reg ? rd_q_reg : '0;

endmodule

// ===== sv/tbb_bound_unit.sv =====
// ----------------------------------------------------------------------------
// Triangle box binner bound unit
// Folds one vertex a cycle into the running bounding box and turns the box
// into clamped ranges of box indices per axis.
// ----------------------------------------------------------------------------
module tbb_bound_unit import tbb_pkg::*; (
    input  logic            aclk,
    input  bound_ctl_t      ctl,
    input  point_t          vertex,
    input  logic [GL_W-1:0] grid_levels,
    input  logic [BL_W-1:0] box_level,
    output box_range_t      range
);

    logic [AXES-1:0][COORD_W-1:0] pv;
    logic [AXES-1:0][COORD_W-1:0] min_reg, min_next;
    logic [AXES-1:0][COORD_W-1:0] max_reg, max_next;
    logic [SH_W-1:0]              sh;
    cnt_t                         nbox;
    logic [COORD_W-1:0]           a_idx  [AXES];
    logic [COORD_W:0]             b_sum  [AXES];
    logic [COORD_W+1:0]           b_idx  [AXES];

    assign pv = vertex;

    always_comb begin
        min_next = min_reg;
        max_next = max_reg;
        for (int d = 0; d < AXES; d++) begin
            if (ctl.load) begin
                min_next[d] = pv[d];
                max_next[d] = pv[d];
            end else if (ctl.acc) begin
                if (pv[d] < min_reg[d]) begin
                    min_next[d] = pv[d];
                end
                if (pv[d] > max_reg[d]) begin
                    max_next[d] = pv[d];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        min_reg <= min_next;
        max_reg <= max_next;
    end

    // The upper end takes max + 1 voxel, which gives the one-voxel halo.
    always_comb begin
        sh   = SH_W'(FRAC_W) + {1'b0, box_level};
        nbox = box_count(grid_levels, box_level);
        range = '0;
        for (int d = 0; d < AXES; d++) begin
            a_idx[d] = min_reg[d] >> sh;
            b_sum[d] = {1'b0, max_reg[d]} + (COORD_W + 1)'(1 << FRAC_W);
            b_idx[d] = {1'b0, b_sum[d] >> sh} + (COORD_W + 2)'(1);
            range.lo[d] = (a_idx[d] > COORD_W'(nbox)) ? nbox : a_idx[d][CNT_W-1:0];
            range.hi[d] = (b_idx[d] > (COORD_W + 2)'(nbox)) ? nbox
                                                              : b_idx[d][CNT_W-1:0];
        end
    end

endmodule

// ===== sv/triangle_box_binner.sv =====
// ----------------------------------------------------------------------------
// Triangle box binner
// Stores points and bins triangles into the boxes of a cubic voxel grid.
// ----------------------------------------------------------------------------
// Input beats arrive on the s_ stream: tuser selects a point load (0) or a
// triangle (1). A point load writes its coordinates into the point memory
// at vertex_a; s_tready stays high. A triangle reads its three vertices one
// per cycle from the single read port of the point memory, folds each into
// the bounding box through the shared compare unit, then turns the box into
// box-index ranges. After that the sequencer emits one touched box per cycle
// while the receiver accepts, on the m_ stream, x slowest and z fastest, with
// tlast on the final box of the triangle. A triangle holds the input until
// its final box is emitted; it touches at most 64 boxes. A triangle that
// touches no box still advances the triangle id and returns to idle.
// Result beats sit in an output register, so the next input beat is taken
// while the final box still waits; if the receiver stalls, the emitter
// waits with it. Reset clears the sequencer, the output valid and the
// triangle counter, and sets the first id to 0, grid levels to 4 and box
// level to 2; the point memory is not cleared and must be written before it
// is read. Configuration must be written through the APB port only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module triangle_box_binner import tbb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // vertex_a, vertex_b, vertex_c, coord_x, coord_y, coord_z, zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // op
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // box_x, box_y, box_z, triangle_id
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_AW-1:0]     paddr,
    input  logic [CFG_DW-1:0]     pwdata,
    output logic [CFG_DW-1:0]     prdata,
    output logic                  pready
);

    // One-hot sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_RD_B  = 6'b000010,
        ST_RD_C  = 6'b000100,
        ST_FOLD  = 6'b001000,
        ST_RANGE = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    localparam int VA_LSB = 0;
    localparam int VB_LSB = VA_LSB + VTX_W;
    localparam int VC_LSB = VB_LSB + VTX_W;
    localparam int PX_LSB = VC_LSB + VTX_W;

    state_t                 state_reg, state_next;
    logic [GL_W-1:0]        gl_reg, gl_next;
    logic [BL_W-1:0]        bl_reg, bl_next;
    logic [ID_W-1:0]        first_id_reg, first_id_next;
    logic [ID_W-1:0]        tri_count_reg, tri_count_next;
    logic [VTX_W-1:0]       vb_reg, vb_next;
    logic [VTX_W-1:0]       vc_reg, vc_next;
    box_range_t             rng_reg, rng_next;
    logic [ID_W-1:0]        tid_reg, tid_next;
    cnt_t                   i_reg, i_next;
    cnt_t                   j_reg, j_next;
    cnt_t                   k_reg, k_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                   m_tlast_reg, m_tlast_next;

    logic [VTX_W-1:0]       in_va, in_vb, in_vc;
    point_t                 in_point;
    logic                   in_fire;
    logic                   cfg_wr;
    logic [CFG_IW-1:0]      cfg_idx;

    logic                   mem_rd_en;
    logic [VTX_W-1:0]       mem_rd_addr;
    point_t                 mem_rd_data;
    bound_ctl_t             bnd_ctl;
    box_range_t             bnd_range;

    logic                   out_free;
    logic                   last_i, last_j, last_k;
    logic [BOX_W-1:0]       box_x, box_y, box_z;

    assign in_va    = s_tdata[VA_LSB +: VTX_W];
    assign in_vb    = s_tdata[VB_LSB +: VTX_W];
    assign in_vc    = s_tdata[VC_LSB +: VTX_W];
    assign in_point = s_tdata[PX_LSB +: 3 * COORD_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------------------------------------------------------------
    // Configuration port: zero-wait APB, one register per word.
    // ---------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[CFG_AW-1:2];

    always_comb begin
        case (cfg_idx)
            REG_GRID_LEVELS: prdata = CFG_DW'(gl_reg);
            REG_BOX_LEVEL:   prdata = CFG_DW'(bl_reg);
            REG_FIRST_ID:    prdata = CFG_DW'(first_id_reg);
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        gl_next       = gl_reg;
        bl_next       = bl_reg;
        first_id_next = first_id_reg;
        if (cfg_wr) begin
            case (cfg_idx)
                REG_GRID_LEVELS: gl_next       = pwdata[GL_W-1:0];
                REG_BOX_LEVEL:   bl_next       = pwdata[BL_W-1:0];
                REG_FIRST_ID:    first_id_next = pwdata[ID_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Point memory and the shared bounding-box unit.
    // The read for vertex a is issued in the cycle the triangle is taken.
    // ---------------------------------------------------------------------
    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = in_va;
        case (state_reg)
            ST_IDLE: begin
                mem_rd_en = in_fire && s_tuser;
            end
            ST_RD_B: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = vb_reg;
            end
            ST_RD_C: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = vc_reg;
            end
            default: ;
        endcase
    end

    tbb_point_mem u_mem (
        .aclk    (aclk),
        .wr_en   (in_fire && !s_tuser),
        .wr_addr (in_va),
        .wr_data (in_point),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign bnd_ctl.load = (state_reg == ST_RD_B);
    assign bnd_ctl.acc  = (state_reg == ST_RD_C) || (state_reg == ST_FOLD);

    tbb_bound_unit u_bound (
        .aclk        (aclk),
        .ctl         (bnd_ctl),
        .vertex      (mem_rd_data),
        .grid_levels (gl_reg),
        .box_level   (bl_reg),
        .range       (bnd_range)
    );

    // ---------------------------------------------------------------------
    // Sequencer and box emitter.
    // ---------------------------------------------------------------------
    assign out_free = !m_tvalid_reg || m_tready;
    assign last_i   = (cnt_t'(i_reg + cnt_t'(1)) == rng_reg.hi[0]);
    assign last_j   = (cnt_t'(j_reg + cnt_t'(1)) == rng_reg.hi[1]);
    assign last_k   = (cnt_t'(k_reg + cnt_t'(1)) == rng_reg.hi[2]);
    assign box_x    = BOX_W'(i_reg) << bl_reg;
    assign box_y    = BOX_W'(j_reg) << bl_reg;
    assign box_z    = BOX_W'(k_reg) << bl_reg;

    always_comb begin
        state_next     = state_reg;
        tri_count_next = tri_count_reg;
        vb_next        = vb_reg;
        vc_next        = vc_reg;
        rng_next       = rng_reg;
        tid_next       = tid_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire && s_tuser) begin
                    vb_next    = in_vb;
                    vc_next    = in_vc;
                    state_next = ST_RD_B;
                end
            end
            ST_RD_B: state_next = ST_RD_C;
            ST_RD_C: state_next = ST_FOLD;
            ST_FOLD: state_next = ST_RANGE;
            ST_RANGE: begin
                rng_next       = bnd_range;
                tid_next       = first_id_reg + tri_count_reg;
                tri_count_next = tri_count_reg + ID_W'(1);
                i_next         = bnd_range.lo[0];
                j_next         = bnd_range.lo[1];
                k_next         = bnd_range.lo[2];
                if ((bnd_range.lo[0] >= bnd_range.hi[0]) ||
                    (bnd_range.lo[1] >= bnd_range.hi[1]) ||
                    (bnd_range.lo[2] >= bnd_range.hi[2])) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {tid_reg, box_z, box_y, box_x};
                    m_tlast_next  = last_i && last_j && last_k;
                    if (!last_k) begin
                        k_next = cnt_t'(k_reg + cnt_t'(1));
                    end else begin
                        k_next = rng_reg.lo[2];
                        if (!last_j) begin
                            j_next = cnt_t'(j_reg + cnt_t'(1));
                        end else begin
                            j_next = rng_reg.lo[1];
                            if (!last_i) begin
                                i_next = cnt_t'(i_reg + cnt_t'(1));
                            end else begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            gl_reg        <= GL_W'(4);
            bl_reg        <= BL_W'(2);
            first_id_reg  <= '0;
            tri_count_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            gl_reg        <= gl_next;
            bl_reg        <= bl_next;
            first_id_reg  <= first_id_next;
            tri_count_reg <= tri_count_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        vb_reg      <= vb_next;
        vc_reg      <= vc_next;
        rng_reg     <= rng_next;
        tid_reg     <= tid_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

// ===== sv/tbb_checker.sv =====
// ----------------------------------------------------------------------------
// Triangle box binner checker
// Port-level properties of the binner, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "triangle_box_binner_macros.svh"

module tbb_checker import tbb_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // A stalled result beat keeps its contents.
    `TBB_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // A triangle closes the input while its vertices are read.
    `TBB_ASSERT_NEXT(a_tri_busy, s_tvalid && s_tready && s_tuser, !s_tready)

    // A point load leaves the input open.
    `TBB_ASSERT_NEXT(a_point_open, s_tvalid && s_tready && !s_tuser, s_tready)

    // While a non-final box waits, the emitter still owns the block.
    `TBB_ASSERT_SAME(a_emit_busy, m_tvalid && !m_tlast, !s_tready)

endmodule

bind triangle_box_binner tbb_checker u_tbb_checker (.*);
